// ===== sv/smpg_pkg.sv =====
// Shared types and codes for the multichannel servo pulse generator.
// No dependencies; imported by every module of the block.
package smpg_pkg;

  // Event kinds on the input stream (tuser)
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_BYTE  = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  // Bus slave phases
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_ADDRESS = 2'd1;
  localparam logic [1:0] PHASE_DATA    = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W          = 2;
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_LED_SLOTS      = 2'd1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd15;
  localparam logic [7:0] LED_SLOTS_RST      = 8'd20;

  localparam int PINS_W   = 10;
  localparam int M_DATA_W = 16;

  // Classified event handed from front to back
  typedef struct packed {
    logic       tick;
    logic       start;
    logic       byte_rx;
    logic       stop;
    logic [7:0] data;
  } op_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

// ===== sv/smpg_front.sv =====
// Front end: accepts input words, decodes the event kind and queues them.
// Depends on smpg_pkg.
module smpg_front
  import smpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [1:0] func
  output q_head_t    head,
  input  logic       pop
);

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_t        op_in;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;

  // one-hot decode of the event kind
  always_comb begin
    op_in         = '0;
    op_in.data    = s_tdata;
    case (s_tuser)
      FUNC_TICK:  op_in.tick    = 1'b1;
      FUNC_START: op_in.start   = 1'b1;
      FUNC_BYTE:  op_in.byte_rx = 1'b1;
      FUNC_STOP:  op_in.stop    = 1'b1;
      default:    op_in.stop    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.op    = q[rd_ptr];

endmodule

// ===== sv/smpg_back.sv =====
// Back end: servo timer, bus slave, activity light and output register.
// Depends on smpg_pkg; fed by smpg_front through its queue head.
module smpg_back
  import smpg_pkg::*;
#(
  parameter int SERVO_CHANNELS = 10,
  parameter int LED_BOOT_SLOTS = 100
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  q_head_t              head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata
);

  localparam int N      = SERVO_CHANNELS;
  localparam int SLOTS  = (N + 1) / 2;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CH_W   = $clog2(N);

  logic [6:0]        device_address;
  logic [7:0]        led_activity_slots;
  logic [7:0]        servo_values [N];
  logic [7:0]        tick_count, tick_count_next;
  logic [SLOT_W-1:0] slot_index, slot_index_next;
  logic [N-1:0]      pulse_levels, pulse_levels_next;
  logic [7:0]        led_timer, led_timer_next;
  logic [1:0]        bus_phase, bus_phase_next;
  logic [CH_W-1:0]   next_channel, next_channel_next;
  logic              val_we;
  logic              ack;
  logic [N-1:0]      raise_mask, clear_mask;
  logic [PINS_W-1:0] pins;
  logic              addr_match;
  op_t               op;

  assign op  = head.op;
  assign pop = head.valid && (!m_tvalid || m_tready);

  // per-channel rise and fall conditions
  for (genvar n = 0; n < N; n++) begin : g_ch
    localparam int SLOT_OF = (n < SLOTS) ? n : n - SLOTS;
    assign raise_mask[n] = (tick_count == 8'd0) && (slot_index == SLOT_W'(SLOT_OF))
                           && (servo_values[n] != 8'd0);
    assign clear_mask[n] = (servo_values[n] == tick_count);
  end

  assign addr_match = (op.data == 8'd0) || (op.data == {device_address, 1'b0});

  always_comb begin
    tick_count_next   = tick_count;
    slot_index_next   = slot_index;
    pulse_levels_next = pulse_levels;
    led_timer_next    = led_timer;
    bus_phase_next    = bus_phase;
    next_channel_next = next_channel;
    val_we            = 1'b0;
    ack               = 1'b0;
    if (op.tick) begin
      pulse_levels_next = (pulse_levels | raise_mask) & ~clear_mask;
      if (tick_count == 8'd0 && led_timer != 8'd0) begin
        led_timer_next = led_timer - 8'd1;
      end
      tick_count_next = tick_count + 8'd1;
      if (tick_count == 8'hFF) begin
        slot_index_next = (slot_index == SLOT_W'(SLOTS - 1)) ? '0 : slot_index + 1'b1;
      end
    end else if (op.start) begin
      bus_phase_next    = PHASE_ADDRESS;
      next_channel_next = '0;
    end else if (op.byte_rx) begin
      case (bus_phase)
        PHASE_ADDRESS: begin
          if (addr_match) begin
            led_timer_next    = led_activity_slots;
            bus_phase_next    = PHASE_DATA;
            next_channel_next = '0;
            ack               = 1'b1;
          end else begin
            bus_phase_next = PHASE_IDLE;
          end
        end
        PHASE_DATA: begin
          val_we = 1'b1;
          ack    = 1'b1;
          if (next_channel == CH_W'(N - 1)) begin
            bus_phase_next = PHASE_IDLE;
          end else begin
            next_channel_next = next_channel + 1'b1;
          end
        end
        default: bus_phase_next = PHASE_IDLE;
      endcase
    end else begin
      bus_phase_next    = PHASE_IDLE;
      next_channel_next = '0;
    end
  end

  // only the first ten channels reach the pins
  for (genvar i = 0; i < PINS_W; i++) begin : g_pin
    if (i < N) begin : g_on
      assign pins[i] = pulse_levels_next[i];
    end else begin : g_off
      assign pins[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {(M_DATA_W - PINS_W - 2)'(0), ack, (led_timer_next != 8'd0), pins};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address     <= DEVICE_ADDRESS_RST;
      led_activity_slots <= LED_SLOTS_RST;
      tick_count         <= 8'd0;
      slot_index         <= '0;
      pulse_levels       <= '0;
      led_timer          <= 8'(LED_BOOT_SLOTS);
      bus_phase          <= PHASE_IDLE;
      next_channel       <= '0;
      m_tvalid           <= 1'b0;
      for (int n = 0; n < N; n++) servo_values[n] <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: device_address     <= cfg_data[6:0];
          CFG_LED_SLOTS:      led_activity_slots <= cfg_data;
          default:            ;
        endcase
      end
      if (pop && val_we) begin
        servo_values[next_channel] <= op.data;
      end
      if (pop) begin
        tick_count   <= tick_count_next;
        slot_index   <= slot_index_next;
        pulse_levels <= pulse_levels_next;
        led_timer    <= led_timer_next;
        bus_phase    <= bus_phase_next;
        next_channel <= next_channel_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/multichannel_servo_pulse_generator_core.sv =====
// Top level of the multichannel servo pulse generator.
// Depends on smpg_pkg, smpg_front and smpg_back.
//
// Servo pulse generator for up to SERVO_CHANNELS hobby servos, loaded over a
// write-only two-wire bus slave. Each input word is one event, selected by
// tuser: a prescaled timer tick, a bus start, a received byte or a bus stop.
// Every input word yields exactly one output word carrying the servo pin
// levels, the activity light and the acknowledge for a received byte.
// An 8-bit tick counter walks through (SERVO_CHANNELS+1)/2 slots of 256 ticks;
// at the start of slot k servos k and k+slots go high unless their value is
// zero, and each servo drops when the counter equals its value. After a bus
// start the first byte is acknowledged when it is 0 or device_address<<1;
// up to SERVO_CHANNELS following bytes load channels 0, 1, ... in order.
// The activity light is lit for LED_BOOT_SLOTS slots after reset and for
// led_activity_slots slots after each address match.
// Throughput is one word per clock while m_tready is high: a two-word queue
// decouples the decode front end from the back end, whose combinational
// update ends in the output register. Config writes are always accepted
// and must only be issued while no words are in flight.
module multichannel_servo_pulse_generator_core
  import smpg_pkg::*;
#(
  parameter int SERVO_CHANNELS = 10,
  parameter int LED_BOOT_SLOTS = 100
)(
  input  logic                 clk,
  input  logic                 rst,
  // input events
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic [1:0]           s_tuser,   // [1:0] func
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [9:0] servo_pins, [10] led_on, [11] ack
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  q_head_t head;
  logic    pop;

  // config registers live in the back end; no back-pressure needed
  assign cfg_ready = 1'b1;

  smpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  smpg_back #(
    .SERVO_CHANNELS (SERVO_CHANNELS),
    .LED_BOOT_SLOTS (LED_BOOT_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/smpg_checker.sv =====
// Port-level checks for the servo pulse generator top level.
// Depends on smpg_pkg; bound to multichannel_servo_pulse_generator_core.
module smpg_checker
  import smpg_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_DATA_W-1:PINS_W+2] == '0)
    else $error("padding bits of output word not zero");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

endmodule

bind multichannel_servo_pulse_generator_core smpg_checker u_smpg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/multichannel_servo_pulse_generator_core_tb.sv =====
// Self-checking bench for multichannel_servo_pulse_generator_core.
// Needs smpg_pkg and the core; a local servo/bus model predicts every output word.
module multichannel_servo_pulse_generator_core_tb;
  import smpg_pkg::*;

  localparam int CHANNELS       = 10;
  localparam int SLOT_COUNT     = (CHANNELS + 1) / 2;
  localparam int LED_BOOT       = 100;
  localparam int PIPE_LATENCY   = 2;
  localparam int DIR_ROWS       = 25;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 165;
  localparam int WATCHDOG_LIMIT = 4000;

  // one output word, split into its fields
  typedef struct packed {
    logic [PINS_W-1:0] pins;
    logic              led;
    logic              ack;
  } servo_status_t;

  // directed row; known rows carry a typed-in expectation
  typedef struct packed {
    logic [1:0]        fn;
    logic [7:0]        b;
    logic              known;
    logic [PINS_W-1:0] pins;
    logic              led;
    logic              ack;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // [7:0] data_byte
  logic [1:0]           s_tuser = '0;   // [1:0] func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;        // [9:0] servo_pins, [10] led_on, [11] ack
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  always #4 clk = ~clk;

  multichannel_servo_pulse_generator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Servo / bus model state
  // ---------------------------------------------------------------------------
  logic [6:0]        m_addr;
  logic [7:0]        m_slots;
  logic [7:0]        m_val [CHANNELS];
  logic [7:0]        m_tick;
  int                m_slot;
  logic [PINS_W-1:0] m_pulse;
  logic [7:0]        m_led;
  logic [1:0]        m_phase;
  int                m_next;

  servo_status_t status_due [$];   // expected output words, oldest first

  int words_in;
  int ticks_sent;
  int settings_used;
  int words_out = 0;
  int acks_seen = 0;
  int mismatches = 0;

  // Advance the model by one event and return the word it should produce.
  task automatic step_servo_model(input logic [1:0] fn, input logic [7:0] b,
                                  output servo_status_t st);
    logic hit;
    hit = 1'b0;
    case (fn)
      FUNC_TICK: begin
        // slot start: rise of both servos of the slot, light counts down
        if (m_tick == 8'd0) begin
          if (m_val[m_slot] != 8'd0) m_pulse[m_slot] = 1'b1;
          if (m_slot + SLOT_COUNT < CHANNELS && m_val[m_slot + SLOT_COUNT] != 8'd0)
            m_pulse[m_slot + SLOT_COUNT] = 1'b1;
          if (m_led != 8'd0) m_led = m_led - 8'd1;
        end
        // fall compares against the live value of each channel
        for (int n = 0; n < CHANNELS; n++)
          if (m_val[n] == m_tick) m_pulse[n] = 1'b0;
        m_tick = m_tick + 8'd1;
        if (m_tick == 8'd0) m_slot = (m_slot == SLOT_COUNT - 1) ? 0 : m_slot + 1;
      end
      FUNC_START: begin
        // also covers a repeated start in any phase
        m_phase = PHASE_ADDRESS;
        m_next  = 0;
      end
      FUNC_BYTE: begin
        if (m_phase == PHASE_ADDRESS) begin
          // whole-byte compare: a read address never matches
          if (b == 8'd0 || b == {m_addr, 1'b0}) begin
            m_led   = m_slots;
            m_phase = PHASE_DATA;
            m_next  = 0;
            hit     = 1'b1;
          end else begin
            m_phase = PHASE_IDLE;
          end
        end else if (m_phase == PHASE_DATA && m_next < CHANNELS) begin
          m_val[m_next] = b;
          hit = 1'b1;
          if (m_next + 1 >= CHANNELS) m_phase = PHASE_IDLE;
          else m_next = m_next + 1;
        end else begin
          // idle, after mismatch, or all channels loaded
          m_phase = PHASE_IDLE;
        end
      end
      default: begin
        m_phase = PHASE_IDLE;
        m_next  = 0;
      end
    endcase
    st.pins = m_pulse;
    st.led  = (m_led != 8'd0);
    st.ack  = hit;
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Random gap first, then offer the word until it is taken. The gap sits in
  // front so valid never gets two updates in one step.
  task automatic send_event(input logic [1:0] fn, input logic [7:0] b,
                            input logic known, input servo_status_t typed);
    servo_status_t predicted;
    while (!(words_in >= 500 && words_in < 650) && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    step_servo_model(fn, b, predicted);
    status_due.push_back(known ? typed : predicted);
    words_in++;
    if (fn == FUNC_TICK) ticks_sent++;
  endtask

  // Stop offering and let everything in flight come out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  // Leaves cfg_valid high; apply_settings drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DEVICE_ADDRESS) m_addr = val[6:0];
    else if (idx == CFG_LED_SLOTS) m_slots = val;
  endtask

  task automatic apply_settings(input logic [7:0] addr, input logic [7:0] slots);
    write_reg(CFG_DEVICE_ADDRESS, addr);
    write_reg(CFG_LED_SLOTS, slots);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One bus transfer: start, address (mostly ours), a few data bytes with the
  // odd tick in between, usually closed by a stop.
  task automatic run_transfer();
    int         pick;
    int         nbytes;
    logic [7:0] addr_b;
    logic [7:0] v;
    pick = $urandom_range(99);
    if (pick < 70) addr_b = {m_addr, 1'b0};
    else if (pick < 80) addr_b = 8'd0;
    else if (pick < 90) addr_b = {m_addr, 1'b1};
    else addr_b = 8'($urandom_range(255));
    send_event(FUNC_START, 8'($urandom_range(255)), 1'b0, '0);
    send_event(FUNC_BYTE, addr_b, 1'b0, '0);
    nbytes = $urandom_range(12);   // past ten: not acknowledged
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(4) == 0)
        send_event(FUNC_TICK, 8'($urandom_range(255)), 1'b0, '0);
      pick = $urandom_range(9);
      if (pick == 0) v = 8'd0;
      else if (pick < 6) v = 8'($urandom_range(1, 60));   // short pulses fall soon
      else v = 8'($urandom_range(255));
      send_event(FUNC_BYTE, v, 1'b0, '0);
    end
    if ($urandom_range(9) < 7) send_event(FUNC_STOP, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern with one long hold-off and a no-stall stretch
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  logic stall_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && words_out >= 300) begin
      // long hold-off: queue fills and s_tready must drop
      stall_done <= 1'b1;
      stall_left <= 80;
      m_tready   <= 1'b0;
    end else if (words_out >= 500 && words_out < 650) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 34);
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at output word %0d: %s", words_out, what);
  endtask

  // Checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    servo_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_out <= words_out + 1;
      if (m_tdata[PINS_W + 1]) acks_seen <= acks_seen + 1;
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_tdata));
      end else begin
        want = status_due.pop_front();
        if (m_tdata[PINS_W-1:0] != want.pins)
          report_mismatch($sformatf("servo_pins exp %b got %b",
                                    want.pins, m_tdata[PINS_W-1:0]));
        if (m_tdata[PINS_W] != want.led)
          report_mismatch($sformatf("led_on exp %b got %b", want.led, m_tdata[PINS_W]));
        if (m_tdata[PINS_W + 1] != want.ack)
          report_mismatch($sformatf("ack exp %b got %b", want.ack, m_tdata[PINS_W + 1]));
      end
    end
  end

  // Watchdog: cycles with no handshake on any channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("multichannel_servo_pulse_generator_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    servo_status_t typed;
    logic [7:0]    addr_tab  [PHASES];
    logic [7:0]    slots_tab [PHASES];
    int            pick;
    int            run_len;
    int            phase_start;

    // model at reset
    m_addr  = DEVICE_ADDRESS_RST;
    m_slots = LED_SLOTS_RST;
    for (int n = 0; n < CHANNELS; n++) m_val[n] = 8'd0;
    m_tick  = 8'd0;
    m_slot  = 0;
    m_pulse = '0;
    m_led   = 8'(LED_BOOT);
    m_phase = PHASE_IDLE;
    m_next  = 0;
    words_in = 0;
    ticks_sent = 0;
    settings_used = 0;

    // No tick follows the first one, so every pin stays low here; the light is
    // on from the boot count, ack only where a byte is taken.
    dir_rows = '{
      '{FUNC_TICK,  8'h00, 1'b1, 10'd0, 1'b1, 1'b0},
      '{FUNC_BYTE,  8'hFF, 1'b1, 10'd0, 1'b1, 1'b0},  // byte with no transfer open
      '{FUNC_STOP,  8'hA5, 1'b1, 10'd0, 1'b1, 1'b0},
      '{FUNC_START, 8'h5A, 1'b1, 10'd0, 1'b1, 1'b0},
      '{FUNC_BYTE,  8'h1F, 1'b1, 10'd0, 1'b1, 1'b0},  // our address with read bit
      '{FUNC_BYTE,  8'h1E, 1'b1, 10'd0, 1'b1, 1'b0},  // ignored after mismatch
      '{FUNC_START, 8'hFF, 1'b1, 10'd0, 1'b1, 1'b0},
      '{FUNC_BYTE,  8'h1E, 1'b1, 10'd0, 1'b1, 1'b1},  // address match
      '{FUNC_BYTE,  8'h01, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'hFF, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h00, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h80, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h02, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h03, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h7F, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h01, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'hFE, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_BYTE,  8'h10, 1'b0, 10'd0, 1'b0, 1'b0},  // tenth channel
      '{FUNC_BYTE,  8'h33, 1'b1, 10'd0, 1'b1, 1'b0},  // all channels loaded
      '{FUNC_START, 8'h00, 1'b1, 10'd0, 1'b1, 1'b0},
      '{FUNC_BYTE,  8'h00, 1'b1, 10'd0, 1'b1, 1'b1},  // general call
      '{FUNC_START, 8'h00, 1'b1, 10'd0, 1'b1, 1'b0},  // repeated start
      '{FUNC_BYTE,  8'h1E, 1'b1, 10'd0, 1'b1, 1'b1},
      '{FUNC_BYTE,  8'h44, 1'b0, 10'd0, 1'b0, 1'b0},
      '{FUNC_STOP,  8'h00, 1'b0, 10'd0, 1'b0, 1'b0}
    };

    // register settings per phase; zero light length and the extremes included
    addr_tab  = '{8'd127, 8'd0, 8'h2A, 8'd0, 8'd1, 8'd15};
    slots_tab = '{8'd255, 8'd1, 8'd0,  8'd0, 8'd128, 8'd20};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      typed.pins = dir_rows[r].pins;
      typed.led  = dir_rows[r].led;
      typed.ack  = dir_rows[r].ack;
      send_event(dir_rows[r].fn, dir_rows[r].b, dir_rows[r].known, typed);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with nothing in flight
      wait_idle();
      if (ph == 3) apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)));
      else apply_settings(addr_tab[ph], slots_tab[ph]);
      phase_start = words_in;
      while (words_in - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // tick runs; some long enough to cross a slot boundary
          run_len = ($urandom_range(9) == 0) ? $urandom_range(200, 300)
                                             : $urandom_range(1, 40);
          for (int t = 0; t < run_len; t++)
            send_event(FUNC_TICK, 8'($urandom_range(255)), 1'b0, '0);
        end else if (pick < 85) begin
          run_transfer();
        end else begin
          send_event(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
        end
      end
    end

    wait_idle();
    $display("%0d input words (%0d ticks) under %0d register settings;",
             words_in, ticks_sent, settings_used);
    $display("%0d output words checked, %0d with a byte acknowledged", words_out, acks_seen);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("multichannel_servo_pulse_generator_core test passed");
    end else begin
      $display("multichannel_servo_pulse_generator_core test failed");
    end
    $finish;
  end

endmodule

// ===== multichannel_servo_pulse_generator_core.f =====
sv/smpg_pkg.sv
sv/smpg_front.sv
sv/smpg_back.sv
sv/multichannel_servo_pulse_generator_core.sv
sv/smpg_checker.sv
bench/multichannel_servo_pulse_generator_core_tb.sv
